>>> hdl/cpp_pkg.sv
// cpp_pkg: shared constants for the closest pair of points search block
// no dependencies; used by cpp_isqrt and closest_pair_points
package cpp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);
    localparam int OUT_IDX_W = 6;
    localparam int DIST_W    = 17;
    localparam int DIST_MAX  = 131071;

    // squared sum width, and key width after saturation to 64 bits
    localparam int SUM_W = 2 * COORD_BITS + 1;
    localparam int KEY_W = (SUM_W > 64) ? 64 : SUM_W;
    localparam int RT_W  = (KEY_W + 1) / 2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_MODE = '0;

    // distance modes; the fourth code behaves as planar
    localparam logic [1:0] MODE_X     = 2'd0;
    localparam logic [1:0] MODE_Y     = 2'd1;
    localparam logic [1:0] MODE_PLANE = 2'd2;

endpackage

>>> hdl/cpp_isqrt.sv
// cpp_isqrt: iterative floor square root, one root bit per cycle
// depends on cpp_pkg (KEY_W, RT_W)
module cpp_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [cpp_pkg::KEY_W-1:0] radicand,
    output logic                      done,
    output logic [cpp_pkg::RT_W-1:0]  root
);
    import cpp_pkg::*;

    localparam int RAD_W  = 2 * RT_W;
    localparam int ITER_W = $clog2(RT_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [RT_W:0]     rem_reg;
    logic [RT_W-1:0]   root_reg;

    logic [RT_W+2:0]   rem_shift;
    logic [RT_W+2:0]   trial;
    logic              take;
    logic [RT_W:0]     rem_next;
    logic [RT_W-1:0]   root_next;

    // bring down the next two radicand bits and try appending a one
    always_comb begin
        rem_shift = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        take      = (rem_shift >= trial);
        rem_next  = take ? (RT_W + 1)'(rem_shift - trial) : rem_shift[RT_W:0];
        root_next = {root_reg[RT_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(RT_W);
            end else if (busy_reg) begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start && !busy_reg |=> busy_reg)
        else $error("square root did not start");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a preceding run");
    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && iter_reg == ITER_W'(1) |=> done_reg)
        else $error("square root did not finish on its last step");
`endif

endmodule

>>> hdl/closest_pair_points.sv
// closest_pair_points: loads a point set, then searches all pairs for the closest one
// depends on cpp_pkg and cpp_isqrt
//
// Usage:
//   Input channel (s_valid/s_ready): one point per beat, s_coord_x and s_coord_y in
//   signed Q8.8. Points load at one per cycle into a 64-entry point memory. A beat
//   with s_last_point set closes the set and starts the search; points past the
//   capacity are dropped and reported through m_points_dropped.
//   Search: one pipelined distance/compare unit visits every pair in load order, one
//   pair per cycle, then the pipeline drains and the result is registered. Planar
//   mode adds a bit-serial square root (one root bit per cycle) before the result is
//   registered. s_ready is low from the last beat until the result is registered.
//   Result channel (m_valid/m_ready): one beat per set, held in an output register
//   until taken. A stalled receiver does not block loading of the next set; only the
//   next result waits for the held one to go.
//   Configuration: distance_mode at address 0 over the APB port, written while idle.
//   Reset (aresetn low, synchronous) empties the set, clears any held result and sets
//   the mode to planar.
module closest_pair_points (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // point input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [cpp_pkg::COORD_BITS-1:0] s_coord_x,
    input  logic signed [cpp_pkg::COORD_BITS-1:0] s_coord_y,
    input  logic                                  s_last_point,
    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cpp_pkg::OUT_IDX_W-1:0]         m_first_index,
    output logic [cpp_pkg::OUT_IDX_W-1:0]         m_second_index,
    output logic [cpp_pkg::DIST_W-1:0]            m_pair_distance,
    output logic                                  m_pair_found,
    output logic                                  m_points_dropped,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cpp_pkg::PADDR_W-1:0]           paddr,
    input  logic [cpp_pkg::PDATA_W-1:0]           pwdata,
    output logic [cpp_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready
);
    import cpp_pkg::*;

    localparam int CB = COORD_BITS;
    localparam logic [SUM_W:0]     KEY_ONE   = 1;
    localparam logic [SUM_W-1:0]   KEY_LIMIT = SUM_W'((KEY_ONE << KEY_W) - KEY_ONE);
    localparam logic [DIST_W-1:0]  DIST_SAT  = DIST_W'(DIST_MAX);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_ROOT,
        ST_RESULT
    } state_t;

    function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic signed [CB:0] d;
        d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
        return d[CB] ? CB'(-d) : CB'(d);
    endfunction

    function automatic logic [DIST_W-1:0] clamp_dist(input logic [KEY_W-1:0] v);
        return (v > KEY_W'(DIST_MAX)) ? DIST_SAT : DIST_W'(v);
    endfunction

    // point memory, x in the upper half
    logic [2*CB-1:0] mem [MAX_POINTS];

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               ovf_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic               found_reg;
    logic [KEY_W-1:0]   best_reg;
    logic [IDX_W-1:0]   bi_reg, bj_reg;
    logic [DIST_W-1:0]  dist_reg;

    logic                  m_valid_reg;
    logic [OUT_IDX_W-1:0]  m_first_index_reg;
    logic [OUT_IDX_W-1:0]  m_second_index_reg;
    logic [DIST_W-1:0]     m_pair_distance_reg;
    logic                  m_pair_found_reg;
    logic                  m_points_dropped_reg;

    // pair pipeline payload
    logic [2*CB-1:0]    pi_reg, pj_reg;
    logic [IDX_W-1:0]   t1_i_reg, t1_j_reg, t2_i_reg, t2_j_reg, t3_i_reg, t3_j_reg;
    logic [CB-1:0]      dx_reg, dy_reg;
    logic [2*CB-1:0]    kx_reg, ky_reg;

    logic               s_fire;
    logic               cfg_write;
    logic [PADDR_W-3:0] reg_idx;
    logic               plane_mode;
    logic [IDX_W-1:0]   last_idx;
    logic               pipe_empty;
    logic [SUM_W-1:0]   key_sum;
    logic [KEY_W-1:0]   key;
    logic               better;
    logic               root_start;
    logic               root_done;
    logic [RT_W-1:0]    root_val;

    assign s_ready    = (state_reg == ST_LOAD);
    assign s_fire     = s_valid && s_ready;
    assign reg_idx    = paddr[PADDR_W-1:2];
    assign cfg_write  = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign prdata     = (reg_idx == REG_MODE) ? PDATA_W'(mode_reg) : '0;
    assign plane_mode = (mode_reg >= MODE_PLANE);
    assign last_idx   = IDX_W'(cnt_reg - 1'b1);
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    // final stage: saturating sum and compare against the best so far
    always_comb begin
        key_sum = {1'b0, kx_reg} + {1'b0, ky_reg};
        key     = (key_sum > KEY_LIMIT) ? KEY_W'(KEY_LIMIT) : KEY_W'(key_sum);
        better  = !found_reg || (key < best_reg);
    end

    assign root_start = (state_reg == ST_DRAIN) && pipe_empty && found_reg && plane_mode;

    cpp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (best_reg),
        .done     (root_done),
        .root     (root_val)
    );

    // memory write and two registered reads
    always_ff @(posedge aclk) begin
        if (s_fire && (cnt_reg < CNT_W'(MAX_POINTS)))
            mem[cnt_reg[IDX_W-1:0]] <= {s_coord_x, s_coord_y};
        pi_reg <= mem[i_reg];
        pj_reg <= mem[j_reg];
    end

    // pair pipeline: read, difference, square or select
    always_ff @(posedge aclk) begin
        t1_i_reg <= i_reg;
        t1_j_reg <= j_reg;
        t2_i_reg <= t1_i_reg;
        t2_j_reg <= t1_j_reg;
        t3_i_reg <= t2_i_reg;
        t3_j_reg <= t2_j_reg;
        dx_reg   <= abs_diff(pi_reg[2*CB-1:CB], pj_reg[2*CB-1:CB]);
        dy_reg   <= abs_diff(pi_reg[CB-1:0], pj_reg[CB-1:0]);
        if (plane_mode) begin
            kx_reg <= dx_reg * dx_reg;
            ky_reg <= dy_reg * dy_reg;
        end else begin
            kx_reg <= (2*CB)'((mode_reg == MODE_Y) ? dy_reg : dx_reg);
            ky_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            mode_reg    <= MODE_PLANE;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_write && reg_idx == REG_MODE)
                mode_reg <= pwdata[1:0];

            v1_reg <= (state_reg == ST_SCAN);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (v3_reg && better) begin
                found_reg <= 1'b1;
                best_reg  <= key;
                bi_reg    <= t3_i_reg;
                bj_reg    <= t3_j_reg;
            end

            // in the result state the held beat is replaced below
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT))
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_LOAD: begin
                    if (s_fire) begin
                        if (cnt_reg < CNT_W'(MAX_POINTS))
                            cnt_reg <= cnt_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        if (s_last_point)
                            state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    i_reg <= '0;
                    j_reg <= IDX_W'(1);
                    if (cnt_reg < CNT_W'(2)) begin
                        dist_reg  <= DIST_SAT;
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (j_reg == last_idx) begin
                        if (i_reg == last_idx - 1'b1) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + IDX_W'(2);
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        if (root_start) begin
                            state_reg <= ST_ROOT;
                        end else begin
                            dist_reg  <= clamp_dist(best_reg);
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_ROOT: begin
                    if (root_done) begin
                        dist_reg  <= clamp_dist(KEY_W'(root_val));
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    // wait for the held beat to go before replacing it
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_first_index_reg    <= found_reg ? OUT_IDX_W'(bi_reg) : '0;
                        m_second_index_reg   <= found_reg ? OUT_IDX_W'(bj_reg) : '0;
                        m_pair_distance_reg  <= dist_reg;
                        m_pair_found_reg     <= found_reg;
                        m_points_dropped_reg <= ovf_reg;
                        found_reg            <= 1'b0;
                        cnt_reg              <= '0;
                        ovf_reg              <= 1'b0;
                        state_reg            <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_first_index    = m_first_index_reg;
    assign m_second_index   = m_second_index_reg;
    assign m_pair_distance  = m_pair_distance_reg;
    assign m_pair_found     = m_pair_found_reg;
    assign m_points_dropped = m_points_dropped_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");
    a_scan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> (i_reg < j_reg) && (j_reg <= last_idx))
        else $error("pair indices out of order");
    a_no_pair_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_pair_found_reg |->
            m_pair_distance_reg == DIST_SAT && m_first_index_reg == '0 &&
            m_second_index_reg == '0)
        else $error("no-pair result not saturated");
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last_point |=> !s_ready)
        else $error("still loading after the last point");
`endif

endmodule
